[rtl/core/efpm_pkg.sv]
// Package for the earliest-finish processing-element mapper.
// Holds the candidate and result item layouts and the fixed field widths.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package efpm_pkg;

  localparam int VERTEX_W = 16;
  localparam int PE_W     = 4;
  localparam int JOB_W    = 16;
  localparam int TIME_W   = 64;

  // One candidate element offered for the current job
  typedef struct packed {
    logic [VERTEX_W-1:0] vertex_number;
    logic [PE_W-1:0]     global_pe;
    logic [PE_W-1:0]     cluster_number;
    logic [PE_W-1:0]     local_pe;
    logic                usable;
    logic [TIME_W-1:0]   exec_time;
    logic                last_candidate;
  } cand_t;

  // One scheduling decision
  typedef struct packed {
    logic [JOB_W-1:0]    job_number;
    logic [VERTEX_W-1:0] vertex_out;
    logic [PE_W-1:0]     chosen_cluster;
    logic [PE_W-1:0]     chosen_local_pe;
    logic [TIME_W-1:0]   start_time;
    logic [TIME_W-1:0]   end_time;
    logic                not_found;
  } result_t;

endpackage

`default_nettype wire

[rtl/core/efpm_chan_if.sv]
// Valid/ready channel interface carrying one payload item per handshake.
// The payload type is chosen per instance (efpm_pkg types in this block).
`timescale 1ns / 1ps
`default_nettype none

interface efpm_chan_if #(
  parameter type T = logic
) ();

  logic valid;
  logic ready;
  T     payload;

  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);

endinterface

`default_nettype wire

[rtl/core/earliest_finish_pe_mapper.sv]
// Earliest-finish processing-element mapper: top level.
// Depends on efpm_pkg, efpm_chan_if and efpm_ready_mem.
//
//  channel | dir | payload  | meaning
//  --------+-----+----------+------------------------------------------------
//  cand    | in  | cand_t   | one candidate element for the current job
//  result  | out | result_t | chosen element and times, on each last candidate
//
// One candidate per cycle sustained unless a last candidate waits on a result
// not yet taken; a result is registered after its last candidate is taken
// (input register with ready-time read, then result register). Ready times
// are read from efpm_ready_mem as a candidate is taken.
// Reset (rst, synchronous) clears the pipeline, running best, job counter
// and all ready times.
// A result that is not taken only holds up a following last candidate;
// other candidates keep flowing into the running best.
`timescale 1ns / 1ps
`default_nettype none

module earliest_finish_pe_mapper #(
  parameter int NUM_PE     = 16,
  parameter int TIME_WIDTH = 64
) (
  input  logic        clk,
  input  logic        rst,
  efpm_chan_if.sink   cand,
  efpm_chan_if.source result
);

  import efpm_pkg::*;

  localparam int IDX_W = (NUM_PE > 1) ? $clog2(NUM_PE) : 1;
  localparam logic [TIME_W-1:0] TMAX64 = {TIME_W{1'b1}} >> (TIME_W - TIME_WIDTH);
  localparam logic [TIME_WIDTH-1:0] TMAX = TMAX64[TIME_WIDTH-1:0];

  // Input register
  logic                  in_vld;
  cand_t                 in_r;
  logic [TIME_WIDTH-1:0] ready_rd;

  // Running best
  logic                  best_valid;
  logic [TIME_WIDTH-1:0] best_cost;
  logic [TIME_WIDTH-1:0] best_start;
  logic [IDX_W-1:0]      best_gpe;
  logic [PE_W-1:0]       best_cluster;
  logic [PE_W-1:0]       best_local;
  logic [JOB_W-1:0]      job_counter;

  // Result register
  logic    out_vld;
  result_t out_r;

  // Candidate evaluation
  logic                  take_in;
  logic                  adv;
  logic [8:0]            gpe_ext;
  logic [8:0]            acc_gpe_ext;
  logic                  cand_ok;
  logic [TIME_WIDTH-1:0] exec_c;
  logic [TIME_WIDTH:0]   sum;
  logic [TIME_WIDTH-1:0] cost;
  logic                  take;
  logic                  m_valid;
  logic [TIME_WIDTH-1:0] m_cost;
  logic [TIME_WIDTH-1:0] m_start;
  logic [IDX_W-1:0]      m_gpe;
  logic [PE_W-1:0]       m_cluster;
  logic [PE_W-1:0]       m_local;
  logic                  wr_en;
  result_t               out_next;

  // Handshakes: a last candidate needs a free result slot to move on
  assign adv     = in_vld && (!in_r.last_candidate || !out_vld || result.ready);
  assign take_in = cand.valid && cand.ready;
  assign cand.ready = !in_vld || adv;

  assign acc_gpe_ext = 9'(cand.payload.global_pe);
  assign gpe_ext     = 9'(in_r.global_pe);

  // Cost = ready time + clipped execution time, saturating
  always_comb begin
    cand_ok = in_r.usable && (gpe_ext < 9'(NUM_PE));
    exec_c  = (in_r.exec_time > TMAX64) ? TMAX : in_r.exec_time[TIME_WIDTH-1:0];
    sum     = {1'b0, ready_rd} + {1'b0, exec_c};
    cost    = sum[TIME_WIDTH] ? TMAX : sum[TIME_WIDTH-1:0];
    take    = cand_ok && (!best_valid || (cost < best_cost));
  end

  // Best after folding in the current candidate
  always_comb begin
    m_valid   = best_valid || take;
    m_cost    = take ? cost : best_cost;
    m_start   = take ? ready_rd : best_start;
    m_gpe     = take ? gpe_ext[IDX_W-1:0] : best_gpe;
    m_cluster = take ? in_r.cluster_number : best_cluster;
    m_local   = take ? in_r.local_pe : best_local;
  end

  // Result item built from the folded best
  always_comb begin
    out_next = '0;
    if (m_valid) begin
      out_next.job_number      = job_counter;
      out_next.vertex_out      = in_r.vertex_number;
      out_next.chosen_cluster  = m_cluster;
      out_next.chosen_local_pe = m_local;
      out_next.start_time      = TIME_W'(m_start);
      out_next.end_time        = TIME_W'(m_cost);
    end else begin
      out_next.not_found = 1'b1;
    end
  end

  assign wr_en = adv && in_r.last_candidate && m_valid;

  efpm_ready_mem #(
    .NUM_PE     (NUM_PE),
    .TIME_WIDTH (TIME_WIDTH),
    .IDX_W      (IDX_W)
  ) u_ready_mem (
    .clk   (clk),
    .rst   (rst),
    .we    (wr_en),
    .waddr (m_gpe),
    .wdata (m_cost),
    .re    (take_in),
    .raddr (acc_gpe_ext[IDX_W-1:0]),
    .rdata (ready_rd)
  );

  // Input register
  always_ff @(posedge clk) begin
    if (rst) begin
      in_vld <= 1'b0;
    end else if (take_in) begin
      in_vld <= 1'b1;
    end else if (adv) begin
      in_vld <= 1'b0;
    end
    if (take_in) begin
      in_r <= cand.payload;
    end
  end

  // Running best and job counter
  always_ff @(posedge clk) begin
    if (rst) begin
      best_valid  <= 1'b0;
      job_counter <= '0;
    end else if (adv) begin
      best_valid <= in_r.last_candidate ? 1'b0 : m_valid;
      if (wr_en) begin
        job_counter <= job_counter + 1'b1;
      end
    end
    if (adv) begin
      best_cost    <= m_cost;
      best_start   <= m_start;
      best_gpe     <= m_gpe;
      best_cluster <= m_cluster;
      best_local   <= m_local;
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_vld <= 1'b0;
    end else if (adv && in_r.last_candidate) begin
      out_vld <= 1'b1;
    end else if (result.ready) begin
      out_vld <= 1'b0;
    end
    if (adv && in_r.last_candidate) begin
      out_r <= out_next;
    end
  end

  assign result.valid   = out_vld;
  assign result.payload = out_r;

  // A new result only follows a last candidate leaving the input register
  a_result_from_last: assert property (@(posedge clk) disable iff (rst)
    !$past(rst) && $rose(out_vld) |-> $past(in_vld && in_r.last_candidate))
    else $error("result raised without a last candidate");

  // A not-found result carries zeros
  a_not_found_zero: assert property (@(posedge clk) disable iff (rst)
    out_vld && out_r.not_found |->
      (out_r.start_time == '0) && (out_r.end_time == '0) && (out_r.job_number == '0))
    else $error("not-found result with non-zero fields");

  // Saturating add never ends before it starts
  a_end_after_start: assert property (@(posedge clk) disable iff (rst)
    out_vld && !out_r.not_found |-> out_r.end_time >= out_r.start_time)
    else $error("end time below start time");

  // Job counter advances exactly on found results
  a_job_count: assert property (@(posedge clk) disable iff (rst)
    !$past(rst) && $past(wr_en) |-> job_counter == $past(job_counter) + 1'b1)
    else $error("job counter did not advance");

endmodule

`default_nettype wire

[rtl/core/efpm_ready_mem.sv]
// Ready-time store: one entry per processing element, registered read,
// write-to-read forwarding, and a valid bit per entry so unwritten entries read zero.
// No package dependencies.
`timescale 1ns / 1ps
`default_nettype none

module efpm_ready_mem #(
  parameter int NUM_PE     = 16,
  parameter int TIME_WIDTH = 64,
  parameter int IDX_W      = 4
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  we,
  input  logic [IDX_W-1:0]      waddr,
  input  logic [TIME_WIDTH-1:0] wdata,
  input  logic                  re,
  input  logic [IDX_W-1:0]      raddr,
  output logic [TIME_WIDTH-1:0] rdata
);

  logic [TIME_WIDTH-1:0] mem [NUM_PE];
  logic [NUM_PE-1:0]     written;
  logic                  raddr_ok;
  logic [TIME_WIDTH-1:0] rdata_next;

  assign raddr_ok = (32'(raddr) < NUM_PE);

  // Forward a write landing on the same edge, else stored value or zero
  always_comb begin
    if (we && (waddr == raddr)) begin
      rdata_next = wdata;
    end else if (raddr_ok && written[raddr]) begin
      rdata_next = mem[raddr];
    end else begin
      rdata_next = '0;
    end
  end

  // Entry valid bits
  always_ff @(posedge clk) begin
    if (rst) begin
      written <= '0;
    end else if (we) begin
      written[waddr] <= 1'b1;
    end
  end

  // Storage and registered read
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= rdata_next;
    end
  end

endmodule

`default_nettype wire
